>>> hdl/crcfd_pkg.sv
`timescale 1ns / 1ps

package crcfd_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD  = 2'd2;

    localparam logic [7:0]  RST_START_MARKER = 8'h02;
    localparam logic [7:0]  RST_END_MARKER   = 8'h03;
    localparam logic [15:0] RST_MAX_PAYLOAD  = 16'd1024;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOR  = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_TYPE   = 4'd1,
        PH_LEN_LO = 4'd2,
        PH_LEN_HI = 4'd3,
        PH_DATA   = 4'd4,
        PH_CRC0   = 4'd5,
        PH_CRC1   = 4'd6,
        PH_CRC2   = 4'd7,
        PH_CRC3   = 4'd8,
        PH_END    = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        ST_MORE  = 2'd0,
        ST_READY = 2'd1,
        ST_CRC   = 2'd2,
        ST_SYNC  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  end_marker;
        logic [15:0] max_payload;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  frame_type;
        logic [15:0] frame_length;
    } result_t;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/crcfd_cfg.sv
`timescale 1ns / 1ps

module crcfd_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [crcfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [crcfd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output crcfd_pkg::cfg_t                      cfg
);

    logic [7:0]  start_marker_reg;
    logic [7:0]  end_marker_reg;
    logic [15:0] max_payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= crcfd_pkg::RST_START_MARKER;
            end_marker_reg   <= crcfd_pkg::RST_END_MARKER;
            max_payload_reg  <= crcfd_pkg::RST_MAX_PAYLOAD;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                crcfd_pkg::CFG_START_MARKER: start_marker_reg <= cfg_data[7:0];
                crcfd_pkg::CFG_END_MARKER:   end_marker_reg   <= cfg_data[7:0];
                crcfd_pkg::CFG_MAX_PAYLOAD:  max_payload_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg.start_marker = start_marker_reg;
    assign cfg.end_marker   = end_marker_reg;
    assign cfg.max_payload  = max_payload_reg;

endmodule

>>> hdl/crcfd_core.sv
`timescale 1ns / 1ps

module crcfd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           in_byte,
    input  crcfd_pkg::cfg_t      cfg,
    output crcfd_pkg::result_t   result
);

    crcfd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] rxcrc_reg, rxcrc_next;
    logic [31:0] crc_reg, crc_next;

    logic [31:0] crc_upd;
    logic [15:0] len_full;
    logic [15:0] count_inc;
    logic        len_bad;
    logic [31:0] crc_final;

    assign crc_upd   = crcfd_pkg::crc_byte(crc_reg, in_byte);
    assign len_full  = {in_byte, length_reg[7:0]};
    assign len_bad   = len_full > cfg.max_payload;
    assign count_inc = count_reg + 16'd1;
    assign crc_final = crc_reg ^ crcfd_pkg::CRC_XOR;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            crcfd_pkg::PH_IDLE:
            begin
                if (in_byte == cfg.start_marker)
                begin
                    phase_next = crcfd_pkg::PH_TYPE;
                end
            end
            crcfd_pkg::PH_TYPE:   phase_next = crcfd_pkg::PH_LEN_LO;
            crcfd_pkg::PH_LEN_LO: phase_next = crcfd_pkg::PH_LEN_HI;
            crcfd_pkg::PH_LEN_HI:
            begin
                if (len_bad)
                begin
                    phase_next = crcfd_pkg::PH_IDLE;
                end
                else if (len_full == 16'd0)
                begin
                    phase_next = crcfd_pkg::PH_CRC0;
                end
                else
                begin
                    phase_next = crcfd_pkg::PH_DATA;
                end
            end
            crcfd_pkg::PH_DATA:
            begin
                if (count_inc >= length_reg)
                begin
                    phase_next = crcfd_pkg::PH_CRC0;
                end
            end
            crcfd_pkg::PH_CRC0: phase_next = crcfd_pkg::PH_CRC1;
            crcfd_pkg::PH_CRC1: phase_next = crcfd_pkg::PH_CRC2;
            crcfd_pkg::PH_CRC2: phase_next = crcfd_pkg::PH_CRC3;
            crcfd_pkg::PH_CRC3: phase_next = crcfd_pkg::PH_END;
            default:            phase_next = crcfd_pkg::PH_IDLE;
        endcase
    end

    always_comb
    begin
        type_next   = type_reg;
        length_next = length_reg;
        count_next  = count_reg;
        rxcrc_next  = rxcrc_reg;
        crc_next    = crc_reg;

        result.status        = crcfd_pkg::ST_MORE;
        result.payload_valid = 1'b0;
        result.payload_byte  = 8'd0;
        result.payload_index = 16'd0;
        result.frame_type    = type_reg;
        result.frame_length  = length_reg;

        case (phase_reg)
            crcfd_pkg::PH_IDLE:
            begin
                if (in_byte == cfg.start_marker)
                begin
                    type_next   = 8'd0;
                    length_next = 16'd0;
                    count_next  = 16'd0;
                    rxcrc_next  = 32'd0;
                    crc_next    = crcfd_pkg::CRC_INIT;
                end
                result.frame_type   = type_next;
                result.frame_length = length_next;
            end
            crcfd_pkg::PH_TYPE:
            begin
                type_next         = in_byte;
                crc_next          = crc_upd;
                result.frame_type = in_byte;
            end
            crcfd_pkg::PH_LEN_LO:
            begin
                length_next         = {8'd0, in_byte};
                crc_next            = crc_upd;
                result.frame_length = length_next;
            end
            crcfd_pkg::PH_LEN_HI:
            begin
                result.frame_length = len_full;
                if (len_bad)
                begin
                    // abort: show offending header, then clear frame state
                    result.status = crcfd_pkg::ST_SYNC;
                    type_next     = 8'd0;
                    length_next   = 16'd0;
                    count_next    = 16'd0;
                    rxcrc_next    = 32'd0;
                    crc_next      = 32'd0;
                end
                else
                begin
                    length_next = len_full;
                    count_next  = 16'd0;
                    crc_next    = crc_upd;
                end
            end
            crcfd_pkg::PH_DATA:
            begin
                result.payload_valid = 1'b1;
                result.payload_byte  = in_byte;
                result.payload_index = count_reg;
                crc_next             = crc_upd;
                count_next           = count_inc;
            end
            crcfd_pkg::PH_CRC0: rxcrc_next = {24'd0, in_byte};
            crcfd_pkg::PH_CRC1: rxcrc_next = rxcrc_reg | {16'd0, in_byte, 8'd0};
            crcfd_pkg::PH_CRC2: rxcrc_next = rxcrc_reg | {8'd0, in_byte, 16'd0};
            crcfd_pkg::PH_CRC3: rxcrc_next = rxcrc_reg | {in_byte, 24'd0};
            crcfd_pkg::PH_END:
            begin
                if (in_byte == cfg.end_marker)
                begin
                    crc_next = crc_final;
                    if (crc_final == rxcrc_reg)
                    begin
                        result.status = crcfd_pkg::ST_READY;
                    end
                    else
                    begin
                        result.status = crcfd_pkg::ST_CRC;
                    end
                end
                else
                begin
                    result.status = crcfd_pkg::ST_SYNC;
                end
            end
            default: result.status = crcfd_pkg::ST_SYNC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= crcfd_pkg::PH_IDLE;
            type_reg   <= 8'd0;
            length_reg <= 16'd0;
            count_reg  <= 16'd0;
            rxcrc_reg  <= 32'd0;
            crc_reg    <= 32'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            rxcrc_reg  <= rxcrc_next;
            crc_reg    <= crc_next;
        end
    end

endmodule

>>> hdl/crc32_frame_decoder.sv
`timescale 1ns / 1ps

// STX/ETX frame decoder with CRC-32 check, one received byte per item.
// Input channel: in_valid/in_stall carry in_byte; an item is taken at a
// clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall carry one result item per input
// item: status, payload_valid, payload_byte, payload_index, frame_type,
// frame_length. Payload bytes are reported with their index, not buffered.
// Configuration: cfg_write/cfg_index/cfg_data write start_marker (0),
// end_marker (1) and max_payload (2); write only while the block is idle.
// Path: an item taken into the input register has its result registered
// in the result register and shown from there on. Throughput: one item
// per cycle while no held result is stalled; the byte-wide CRC update and
// the phase step are combinational between the input and result registers.
// Reset: markers return to 2 and 3, max_payload to 1024, the decoder waits
// for a start marker and both registers are empty.
// Stall: a held result stays on the outputs; an empty input register
// still takes one item, then in_stall stays high until out_stall drops.
module crc32_frame_decoder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           in_byte,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    output logic                                 payload_valid,
    output logic [7:0]                           payload_byte,
    output logic [15:0]                          payload_index,
    output logic [7:0]                           frame_type,
    output logic [15:0]                          frame_length,
    input  logic                                 cfg_write,
    input  logic [crcfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [crcfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    crcfd_pkg::cfg_t    cfg;
    crcfd_pkg::result_t step_result;
    crcfd_pkg::result_t res_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       step;

    assign out_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    crcfd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crcfd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= in_byte;
        end
        if (step)
        begin
            res_reg <= step_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = res_reg.status;
    assign payload_valid = res_reg.payload_valid;
    assign payload_byte  = res_reg.payload_byte;
    assign payload_index = res_reg.payload_index;
    assign frame_type    = res_reg.frame_type;
    assign frame_length  = res_reg.frame_length;

endmodule

>>> hdl/crcfd_checker.sv
`timescale 1ns / 1ps

module crcfd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic        payload_valid,
    input  logic [7:0]  payload_byte,
    input  logic [15:0] payload_index
);

    // held result must not move
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(payload_valid) && $stable(payload_byte) && $stable(payload_index))
        else $error("result changed while stalled");

    // input side only backs up behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // a payload item never carries a frame verdict
    a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |-> status == crcfd_pkg::ST_MORE)
        else $error("payload item with non-zero status");

    // non-payload items report zero byte and index
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !payload_valid |-> payload_byte == 8'd0 && payload_index == 16'd0)
        else $error("payload fields set outside payload");

endmodule

bind crc32_frame_decoder crcfd_checker u_crcfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .payload_index (payload_index)
);
